// ===== rtl/core/matrix_chain_order_assert.svh =====
// Assertion macros shared by the matrix-chain order RTL.
`ifndef MATRIX_CHAIN_ORDER_ASSERT_SVH
`define MATRIX_CHAIN_ORDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mco_pkg.sv =====
// Types, constants and the step program of the matrix-chain order block.
package mco_pkg;

    localparam int MAX_MATRICES_DEF = 8;
    localparam int DIM_BITS_DEF     = 10;
    localparam int DIM_FIELD_W      = 10;
    localparam int IDX_W            = 4;
    localparam int COST_W           = 40;
    localparam logic [COST_W-1:0] COST_MAX = '1;

    typedef struct packed {
        logic [DIM_FIELD_W-1:0] dim_value;
        logic                   is_last;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]  from_matrix;
        logic [IDX_W-1:0]  to_matrix;
        logic [IDX_W-1:0]  best_split;
        logic [COST_W-1:0] min_cost;
        logic              bad_length;
        logic              end_of_run;
    } t_out_item;

    // Datapath operations, one per step.
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_SETUP,
        UOP_SUB_INIT,
        UOP_LATCH_DIM,
        UOP_K_READ,
        UOP_MUL1,
        UOP_MUL2,
        UOP_CMP,
        UOP_EMIT,
        UOP_EMIT_ERR,
        UOP_EMIT_ONE
    } t_uop;

    // Jump conditions; the jump is taken when the condition is true.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_WAIT,
        C_BAD,
        C_SINGLE,
        C_K_MORE,
        C_I_MORE,
        C_LEN_DONE
    } t_cond;

    typedef logic [3:0] t_step;

    localparam t_step ST_IDLE  = 4'd0;
    localparam t_step ST_SETUP = 4'd1;
    localparam t_step ST_CHK_B = 4'd2;
    localparam t_step ST_CHK_1 = 4'd3;
    localparam t_step ST_SUB   = 4'd4;
    localparam t_step ST_DIMS  = 4'd5;
    localparam t_step ST_KLOOP = 4'd6;
    localparam t_step ST_MUL1  = 4'd7;
    localparam t_step ST_MUL2  = 4'd8;
    localparam t_step ST_CMP   = 4'd9;
    localparam t_step ST_EMIT  = 4'd10;
    localparam t_step ST_LEN   = 4'd11;
    localparam t_step ST_NEXT  = 4'd12;
    localparam t_step ST_ERR   = 4'd13;
    localparam t_step ST_ONE   = 4'd14;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic wait_more;
        logic bad;
        logic single;
        logic k_more;
        logic i_more;
        logic len_done;
    } t_flags;

    typedef struct packed {
        t_uop op;
        logic busy;
    } t_ctrl;

    // Control store: one word per step.
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        case (step)
            ST_IDLE:  w = '{UOP_LOAD,      C_WAIT,     ST_IDLE};
            ST_SETUP: w = '{UOP_SETUP,     C_NEVER,    ST_IDLE};
            ST_CHK_B: w = '{UOP_NOP,       C_BAD,      ST_ERR};
            ST_CHK_1: w = '{UOP_NOP,       C_SINGLE,   ST_ONE};
            ST_SUB:   w = '{UOP_SUB_INIT,  C_NEVER,    ST_IDLE};
            ST_DIMS:  w = '{UOP_LATCH_DIM, C_NEVER,    ST_IDLE};
            ST_KLOOP: w = '{UOP_K_READ,    C_NEVER,    ST_IDLE};
            ST_MUL1:  w = '{UOP_MUL1,      C_NEVER,    ST_IDLE};
            ST_MUL2:  w = '{UOP_MUL2,      C_NEVER,    ST_IDLE};
            ST_CMP:   w = '{UOP_CMP,       C_K_MORE,   ST_KLOOP};
            ST_EMIT:  w = '{UOP_EMIT,      C_I_MORE,   ST_SUB};
            ST_LEN:   w = '{UOP_NOP,       C_LEN_DONE, ST_IDLE};
            ST_NEXT:  w = '{UOP_NOP,       C_ALWAYS,   ST_SUB};
            ST_ERR:   w = '{UOP_EMIT_ERR,  C_ALWAYS,   ST_IDLE};
            ST_ONE:   w = '{UOP_EMIT_ONE,  C_ALWAYS,   ST_IDLE};
            default:  w = '{UOP_NOP,       C_ALWAYS,   ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/mco_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module mco_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/core/mco_seq.sv =====
// Step counter and control store of the matrix-chain order block.
module mco_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mco_pkg::t_flags i_flags,
    output mco_pkg::t_ctrl  o_ctrl
);

    mco_pkg::t_step  r_upc;
    mco_pkg::t_step  n_upc;
    mco_pkg::t_uword word;
    logic            taken;

    assign word = mco_pkg::ucode(r_upc);

    always_comb begin
        case (word.cond)
            mco_pkg::C_NEVER:    taken = 1'b0;
            mco_pkg::C_ALWAYS:   taken = 1'b1;
            mco_pkg::C_WAIT:     taken = i_flags.wait_more;
            mco_pkg::C_BAD:      taken = i_flags.bad;
            mco_pkg::C_SINGLE:   taken = i_flags.single;
            mco_pkg::C_K_MORE:   taken = i_flags.k_more;
            mco_pkg::C_I_MORE:   taken = i_flags.i_more;
            mco_pkg::C_LEN_DONE: taken = i_flags.len_done;
            default:             taken = 1'b1;
        endcase
        n_upc = taken ? word.target : r_upc + 4'd1;
    end

    always_comb begin
        o_ctrl.op   = word.op;
        o_ctrl.busy = (r_upc != mco_pkg::ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= mco_pkg::ST_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== rtl/core/matrix_chain_order.sv =====
// Matrix-chain order: the dimension list p0..pn arrives one value per transaction, at one
// transaction per cycle while busy is low; the transaction with is_last set closes the list.
// The block then raises busy and solves the chain by increasing sub-chain length, giving
// one result strobe per sub-chain (i,j) in length-then-start order; the last one carries
// end_of_run and the whole chain's least cost. Results cannot be held off, so they must be
// taken in the cycle they are shown. After the closing value, setup checks the list for a bad
// length and a single matrix; each sub-chain then latches p(i-1) and p(j), tries each split
// point in turn (read, two multiplies, compare on one shared datapath driven by the step
// program) and shows its result. A bad list gives one error result with bad_length set, a
// single-matrix list one result of zero cost.
`include "matrix_chain_order_assert.svh"

module matrix_chain_order #(
    parameter int MAX_MATRICES = mco_pkg::MAX_MATRICES_DEF,
    parameter int DIM_BITS     = mco_pkg::DIM_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  mco_pkg::t_in_item  i_item,
    output logic               o_result_strobe,
    output mco_pkg::t_out_item o_result
);

    localparam int SLOTS  = MAX_MATRICES + 1;
    localparam int IW     = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CDEPTH = MAX_MATRICES * MAX_MATRICES;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int DW     = DIM_BITS;
    localparam int PW     = 3 * DW;
    localparam int CW     = mco_pkg::COST_W;
    localparam int SW     = (PW > CW) ? PW : CW + 1;
    localparam int XW     = mco_pkg::IDX_W;

    mco_pkg::t_ctrl  ctrl;
    mco_pkg::t_flags flags;
    logic            accept;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_too_many;
    logic             n_too_many;
    logic             r_strobe;
    logic             n_strobe;

    logic             r_bad;
    logic [IW-1:0]    r_n;
    logic [CNT_W-1:0] r_len;
    logic [IW-1:0]    r_i;
    logic [IW-1:0]    r_j;
    logic [IW-1:0]    r_k;
    logic             r_first;
    logic             r_ldiag;
    logic             r_rdiag;
    logic [DW-1:0]    r_pi;
    logic [DW-1:0]    r_pj;
    logic [2*DW-1:0]  r_prod1;
    logic [PW-1:0]    r_prod;
    logic [CW-1:0]    r_cl;
    logic [CW-1:0]    r_cr;
    logic [CW-1:0]    r_csum;
    logic [CW-1:0]    r_best;
    logic [IW-1:0]    r_best_k;
    mco_pkg::t_out_item r_result;

    logic [IW-1:0]  j_calc;
    logic           dim_we;
    logic [IW-1:0]  dim_raddr_a;
    logic [DW-1:0]  dim_rd_a;
    logic [DW-1:0]  dim_rd_b;
    logic           cost_we;
    logic [CAW-1:0] cost_waddr;
    logic [CAW-1:0] cost_raddr_a;
    logic [CAW-1:0] cost_raddr_b;
    logic [CW-1:0]  cost_rd_a;
    logic [CW-1:0]  cost_rd_b;

    logic [SW-1:0]  prod_ext;
    logic [CW-1:0]  prod_sat;
    logic [CW:0]    sum_lr;
    logic [CW-1:0]  csum_next;
    logic [CW:0]    sum_tot;
    logic [CW-1:0]  c_val;

    assign busy   = ctrl.busy;
    assign accept = start && !busy;

    mco_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    always_comb begin
        flags.wait_more = !(start && i_item.is_last);
        flags.bad       = r_bad;
        flags.single    = (r_n == IW'(1));
        flags.k_more    = (int'(r_k) + 1) < int'(r_j);
        flags.i_more    = (r_j < r_n);
        flags.len_done  = int'(r_len) > int'(r_n);
    end

    // Dimension store: written while loading, read for p(i-1) and p(j) at the start of a
    // sub-chain and for p(k) once per split point.
    assign j_calc      = IW'(int'(r_i) + int'(r_len) - 1);
    assign dim_we      = (ctrl.op == mco_pkg::UOP_LOAD) && accept && (int'(r_cnt) < SLOTS);
    assign dim_raddr_a = (ctrl.op == mco_pkg::UOP_K_READ) ? r_k : r_i - IW'(1);

    mco_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_dim_ram (
        .i_clk     (i_clk),
        .i_we      (dim_we),
        .i_waddr   (r_cnt[IW-1:0]),
        .i_wdata   (DW'(i_item.dim_value)),
        .i_raddr_a (dim_raddr_a),
        .i_raddr_b (j_calc),
        .o_rdata_a (dim_rd_a),
        .o_rdata_b (dim_rd_b)
    );

    // Cost table, row i-1 and column j-1. Single-matrix entries are never stored; the
    // diagonal flags force those operands to zero instead.
    assign cost_we      = (ctrl.op == mco_pkg::UOP_EMIT);
    assign cost_waddr   = CAW'((int'(r_i) - 1) * MAX_MATRICES + int'(r_j) - 1);
    assign cost_raddr_a = CAW'((int'(r_i) - 1) * MAX_MATRICES + int'(r_k) - 1);
    assign cost_raddr_b = CAW'(int'(r_k) * MAX_MATRICES + int'(r_j) - 1);

    mco_ram #(
        .WIDTH (CW),
        .DEPTH (CDEPTH)
    ) u_cost_ram (
        .i_clk     (i_clk),
        .i_we      (cost_we),
        .i_waddr   (cost_waddr),
        .i_wdata   (r_best),
        .i_raddr_a (cost_raddr_a),
        .i_raddr_b (cost_raddr_b),
        .o_rdata_a (cost_rd_a),
        .o_rdata_b (cost_rd_b)
    );

    // Saturating cost arithmetic; both addends never exceed the cap, so the carry flags
    // an overflow.
    always_comb begin
        prod_ext  = SW'(r_prod);
        prod_sat  = (prod_ext > SW'(mco_pkg::COST_MAX)) ? mco_pkg::COST_MAX
                                                         : prod_ext[CW-1:0];
        sum_lr    = {1'b0, r_cl} + {1'b0, r_cr};
        csum_next = sum_lr[CW] ? mco_pkg::COST_MAX : sum_lr[CW-1:0];
        sum_tot   = {1'b0, r_csum} + {1'b0, prod_sat};
        c_val     = sum_tot[CW] ? mco_pkg::COST_MAX : sum_tot[CW-1:0];
    end

    always_comb begin
        n_cnt      = r_cnt;
        n_too_many = r_too_many;
        if ((ctrl.op == mco_pkg::UOP_LOAD) && accept) begin
            if (int'(r_cnt) < SLOTS) begin
                n_cnt = r_cnt + CNT_W'(1);
            end else begin
                n_too_many = 1'b1;
            end
        end else if (ctrl.op == mco_pkg::UOP_SETUP) begin
            n_cnt      = '0;
            n_too_many = 1'b0;
        end
        n_strobe = ctrl.op inside {mco_pkg::UOP_EMIT, mco_pkg::UOP_EMIT_ERR,
                                   mco_pkg::UOP_EMIT_ONE};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_too_many <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_too_many <= n_too_many;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        case (ctrl.op)
            mco_pkg::UOP_SETUP: begin
                r_bad <= r_too_many || (int'(r_cnt) < 2);
                r_n   <= IW'(int'(r_cnt) - 1);
                r_len <= CNT_W'(2);
                r_i   <= IW'(1);
            end
            mco_pkg::UOP_SUB_INIT: begin
                r_j     <= j_calc;
                r_k     <= r_i;
                r_first <= 1'b1;
            end
            mco_pkg::UOP_LATCH_DIM: begin
                r_pi <= dim_rd_a;
                r_pj <= dim_rd_b;
            end
            mco_pkg::UOP_K_READ: begin
                r_ldiag <= (r_k == r_i);
                r_rdiag <= ((r_k + IW'(1)) == r_j);
            end
            mco_pkg::UOP_MUL1: begin
                r_prod1 <= (2 * DW)'(r_pi) * (2 * DW)'(dim_rd_a);
                r_cl    <= r_ldiag ? '0 : cost_rd_a;
                r_cr    <= r_rdiag ? '0 : cost_rd_b;
            end
            mco_pkg::UOP_MUL2: begin
                r_prod <= PW'(r_prod1) * PW'(r_pj);
                r_csum <= csum_next;
            end
            mco_pkg::UOP_CMP: begin
                // Strict compare keeps the lower split on a tie.
                if (r_first || (c_val < r_best)) begin
                    r_best   <= c_val;
                    r_best_k <= r_k;
                end
                r_first <= 1'b0;
                r_k     <= r_k + IW'(1);
            end
            mco_pkg::UOP_EMIT: begin
                r_result.from_matrix <= XW'(r_i);
                r_result.to_matrix   <= XW'(r_j);
                r_result.best_split  <= XW'(r_best_k);
                r_result.min_cost    <= r_best;
                r_result.bad_length  <= 1'b0;
                r_result.end_of_run  <= (int'(r_len) == int'(r_n));
                if (flags.i_more) begin
                    r_i <= r_i + IW'(1);
                end else begin
                    r_i   <= IW'(1);
                    r_len <= r_len + CNT_W'(1);
                end
            end
            mco_pkg::UOP_EMIT_ERR: begin
                r_result.from_matrix <= '0;
                r_result.to_matrix   <= '0;
                r_result.best_split  <= '0;
                r_result.min_cost    <= '0;
                r_result.bad_length  <= 1'b1;
                r_result.end_of_run  <= 1'b1;
            end
            mco_pkg::UOP_EMIT_ONE: begin
                r_result.from_matrix <= XW'(1);
                r_result.to_matrix   <= XW'(1);
                r_result.best_split  <= '0;
                r_result.min_cost    <= '0;
                r_result.bad_length  <= 1'b0;
                r_result.end_of_run  <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    `MCO_ASSERT_NEXT(a_busy_after_close, i_clk, i_rst_n, start && !busy && i_item.is_last, busy, "closing transaction did not start the solve")
    `MCO_ASSERT_NEXT(a_quiet_while_loading, i_clk, i_rst_n, start && !busy && !i_item.is_last, !o_result_strobe, "result shown while a list is loading")
    `MCO_ASSERT_SAME(a_error_shape, i_clk, i_rst_n, o_result_strobe && o_result.bad_length, o_result.end_of_run && (o_result.min_cost == '0) && (o_result.from_matrix == '0), "malformed error result")
    `MCO_ASSERT_SAME(a_split_in_range, i_clk, i_rst_n, o_result_strobe && !o_result.bad_length && (o_result.from_matrix != o_result.to_matrix), (o_result.best_split >= o_result.from_matrix) && (o_result.best_split < o_result.to_matrix), "split point outside its sub-chain")

endmodule
